/* rtl/hjp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hjp_pkg
// Shared types and constants for the linear-probing hash join probe block.
// ----------------------------------------------------------------------------
package hjp_pkg;

	localparam int SLOTS       = 4096;
	localparam int SLOT_W      = 12;
	localparam int STEP_W      = SLOT_W + 1;
	localparam int MAX_MATCHES = 64;
	localparam int CNT_W       = 7;
	localparam int HASH_W      = 64;
	localparam int PAGE_W      = 16;
	localparam int OFFS_W      = 16;
	localparam int TAG_W       = 10;
	localparam int LOC_W       = PAGE_W + OFFS_W;
	localparam int PADDR_W     = 2;
	localparam int PDATA_W     = 32;

	localparam logic [SLOT_W-1:0] MASK_RESET = 12'hFFF;

	// Register byte addresses.
	localparam logic [PADDR_W-1:0] ADDR_BUCKET_MASK = '0;

	// Request kinds.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_PROBE = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [SLOT_W-1:0] slot_index;
		logic [HASH_W-1:0] hash_value;
		logic [PAGE_W-1:0] page_number;
		logic [OFFS_W-1:0] page_offset;
		logic [TAG_W-1:0]  probe_tag;
	} req_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag_out;
		logic              hit;
		logic [PAGE_W-1:0] found_page;
		logic [OFFS_W-1:0] found_offset;
		logic [SLOT_W-1:0] found_slot;
		logic              last;
		logic              truncated;
	} rsp_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [OFFS_W-1:0] offset;
	} loc_t;

	// Slot store access issued by the walk controller.
	typedef struct packed {
		logic              we_hash;
		logic              we_loc;
		logic [SLOT_W-1:0] addr;
		logic [HASH_W-1:0] wr_hash;
		loc_t              wr_loc;
	} mem_cmd_t;

	typedef struct packed {
		logic valid;
		rsp_t rsp;
	} emit_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL,
		ST_FLUSH
	} state_t;

endpackage : hjp_pkg
`default_nettype wire

/* rtl/hash_join_probe_linear.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hash_join_probe_linear
// Probe side of a hash join over an open-addressing slot table with linear
// probing: slot writes, chain walks and the result output register.
// ----------------------------------------------------------------------------
// Usage:
// A request on the req channel either writes one slot (hash plus page and
// offset, page zero meaning empty) or probes with a hash. A probe starts at
// hash AND bucket_mask and walks the slots circularly until an empty slot,
// a full lap of the table, or the match limit. Each match yields one
// response on the rsp channel; a probe with no match yields a single miss
// response. The final response of a probe carries last.
// A write is applied when it is accepted. On a probe the accept cycle issues
// the first slot read, each slot is then judged from the registered store
// read, and a flush state sends the final response. The single-port slot
// stores set a pace of one slot per cycle unless a held response blocks the
// output, and one request is worked on at a time.
// After reset the location store is swept to zero, during which req_stall
// stays high; configuration writes are taken throughout.
// When rsp_stall holds the output register full, the walk waits in place.
// ----------------------------------------------------------------------------
module hash_join_probe_linear
	import hjp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire req_t               req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output rsp_t                    rsp,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	// The only register, bucket_mask, sits at byte address zero. Reads
	// always return it.
	logic [SLOT_W-1:0] bucket_mask_q;
	logic              cfg_write;

	assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_BUCKET_MASK);
	assign pready    = 1'b1;
	assign prdata    = {{(PDATA_W - SLOT_W){1'b0}}, bucket_mask_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_mask_q <= MASK_RESET;
		end else if (cfg_write) begin
			bucket_mask_q <= pwdata[SLOT_W-1:0];
		end
	end

	// Slot stores: the hash store needs no clearing since a slot hash is
	// only compared once its page is nonzero, which takes a write.
	mem_cmd_t          mem;
	logic [HASH_W-1:0] rd_hash;
	logic [LOC_W-1:0]  rd_loc_bits;
	loc_t              rd_loc;

	hjp_ram #(
		.WIDTH(HASH_W),
		.DEPTH(SLOTS)
	) u_hash_ram (
		.clk  (clk),
		.we   (mem.we_hash),
		.addr (mem.addr),
		.wdata(mem.wr_hash),
		.rdata(rd_hash)
	);

	hjp_ram #(
		.WIDTH(LOC_W),
		.DEPTH(SLOTS)
	) u_loc_ram (
		.clk  (clk),
		.we   (mem.we_loc),
		.addr (mem.addr),
		.wdata(mem.wr_loc),
		.rdata(rd_loc_bits)
	);

	assign rd_loc = rd_loc_bits;

	// Output register. It takes a new response in the same cycle that the
	// held one leaves, so the walk never loses a cycle on a drained output.
	emit_t emit;
	logic  out_free;
	logic  rsp_valid_q;
	rsp_t  rsp_q;

	assign out_free = !rsp_valid_q || !rsp_stall;

	hjp_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.bucket_mask(bucket_mask_q),
		.rd_hash    (rd_hash),
		.rd_loc     (rd_loc),
		.out_free   (out_free),
		.mem        (mem),
		.emit       (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit.valid) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			rsp_q <= emit.rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The walk must never overwrite a response that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> out_free)
		else $error("response emitted into a full output register");

	// A slot hash is written only by an accepted write request.
	assert property (@(posedge clk) disable iff (!arst_n)
		mem.we_hash |-> (req_valid && !req_stall && (req.req_type == REQ_WRITE)))
		else $error("slot hash written without an accepted write request");

	// A truncated walk always ends the probe on a hit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.truncated) |-> (rsp.last && rsp.hit))
		else $error("truncated response that is not a final hit");

	// A miss is always the single, final response of its probe.
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && !emit.rsp.hit) |->
			(emit.rsp.last && (emit.rsp.found_page == '0)))
		else $error("miss response that is not final or carries a location");

endmodule : hash_join_probe_linear
`default_nettype wire

/* rtl/hjp_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hjp_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module hjp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule : hjp_ram
`default_nettype wire

/* rtl/hjp_walk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hjp_walk
// Walk controller: clears the location store after reset, applies slot writes,
// walks the probe chain one slot per cycle while the output has room, and emits responses.
// ----------------------------------------------------------------------------
module hjp_walk
	import hjp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire req_t              req,
	input  wire logic [SLOT_W-1:0] bucket_mask,
	input  wire logic [HASH_W-1:0] rd_hash,
	input  wire loc_t              rd_loc,
	input  wire logic              out_free,
	output mem_cmd_t               mem,
	output emit_t                  emit
);

	state_t            state_q, state_d;
	logic [SLOT_W-1:0] clr_cnt_q;
	logic [SLOT_W-1:0] pos_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [HASH_W-1:0] probe_hash_q;
	logic [TAG_W-1:0]  tag_q;
	logic              pend_valid_q;
	loc_t              pend_loc_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic              trunc_q;

	logic              slot_empty;
	logic              slot_match;
	logic              lap_end;
	logic              limit_hit;
	logic              eval_wait;
	logic              walk_done;
	logic [SLOT_W-1:0] next_pos;
	logic              accept;

	assign accept     = (state_q == ST_IDLE) && req_valid;
	assign slot_empty = (rd_loc.page == '0);
	assign slot_match = !slot_empty && (rd_hash == probe_hash_q);
	assign lap_end    = (step_q == {1'b0, bucket_mask});
	assign limit_hit  = (cnt_q == CNT_W'(MAX_MATCHES - 1));
	assign eval_wait  = slot_match && pend_valid_q && !out_free;
	assign walk_done  = slot_empty || (slot_match && limit_hit) || lap_end;
	assign next_pos   = (pos_q == bucket_mask) ? '0 : pos_q + SLOT_W'(1);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == SLOT_W'(SLOTS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid && (req.req_type == REQ_PROBE)) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!eval_wait && walk_done) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: store accesses, input stall and result emission.
	always_comb begin
		req_stall   = 1'b1;
		mem         = '0;
		mem.addr    = pos_q;
		emit        = '0;
		emit.rsp.tag_out = tag_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem.we_loc = 1'b1;
				mem.addr   = clr_cnt_q;
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req.req_type == REQ_WRITE) begin
					mem.we_hash = req_valid;
					mem.we_loc  = req_valid;
					mem.addr    = req.slot_index;
				end else begin
					mem.addr = req.hash_value[SLOT_W-1:0] & bucket_mask;
				end
				mem.wr_hash       = req.hash_value;
				mem.wr_loc.page   = req.page_number;
				mem.wr_loc.offset = req.page_offset;
			end
			ST_EVAL: begin
				if (!eval_wait && !walk_done) begin
					mem.addr = next_pos;
				end
				// A new match pushes the held one out; it cannot be the last.
				if (slot_match && pend_valid_q && out_free) begin
					emit.valid            = 1'b1;
					emit.rsp.hit          = 1'b1;
					emit.rsp.found_page   = pend_loc_q.page;
					emit.rsp.found_offset = pend_loc_q.offset;
					emit.rsp.found_slot   = pend_slot_q;
				end
			end
			ST_FLUSH: begin
				emit.valid    = out_free;
				emit.rsp.last = 1'b1;
				if (pend_valid_q) begin
					emit.rsp.hit          = 1'b1;
					emit.rsp.found_page   = pend_loc_q.page;
					emit.rsp.found_offset = pend_loc_q.offset;
					emit.rsp.found_slot   = pend_slot_q;
					emit.rsp.truncated    = trunc_q;
				end
			end
			default: req_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_cnt_q    <= '0;
			pos_q        <= '0;
			step_q       <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			trunc_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
			end
			if (accept && (req.req_type == REQ_PROBE)) begin
				pos_q        <= req.hash_value[SLOT_W-1:0] & bucket_mask;
				step_q       <= '0;
				cnt_q        <= '0;
				pend_valid_q <= 1'b0;
				trunc_q      <= 1'b0;
			end
			if ((state_q == ST_EVAL) && !eval_wait) begin
				if (slot_match) begin
					pend_valid_q <= 1'b1;
					cnt_q        <= cnt_q + CNT_W'(1);
					if (limit_hit) begin
						trunc_q <= 1'b1;
					end
				end
				if (!walk_done) begin
					pos_q  <= next_pos;
					step_q <= step_q + STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			probe_hash_q <= req.hash_value;
			tag_q        <= req.probe_tag;
		end
		if ((state_q == ST_EVAL) && !eval_wait && slot_match) begin
			pend_loc_q  <= rd_loc;
			pend_slot_q <= pos_q;
		end
	end

endmodule : hjp_walk
`default_nettype wire
